>>> sv/urc_pkg.sv
package urc_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = 1;

	localparam logic [7:0]  UDP_PROTO = 8'd17;
	localparam logic [15:0] HDR_BYTES = 16'd8;
	localparam logic [15:0] MASK16    = 16'hFFFF;
	// folded sum of 0xFFFF: either 0xFFFF plain, or 0xFFFE with the carry bit set
	localparam logic [15:0] SUM_OK_LO = 16'hFFFE;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT   = 2'd0,
		VERDICT_INVALID  = 2'd1,
		VERDICT_LEN_ERR  = 2'd2,
		VERDICT_CSUM_ERR = 2'd3
	} verdict_t;

	// state snapshot after the last byte of a segment
	typedef struct packed {
		logic [7:0]  proto;
		logic [15:0] ip_len;
		logic [15:0] count;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] hdr_len;
		logic [15:0] rx_csum;
		logic [18:0] acc;
		logic [7:0]  held;
	} urc_rec_t;

	typedef struct packed {
		logic push;
	} urc_qctl_t;

endpackage

>>> sv/urc_if.sv
interface urc_seg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first;
	logic        last;
	logic [31:0] ip_src;
	logic [31:0] ip_dst;
	logic [7:0]  protocol;
	logic [15:0] ip_payload_length;

	modport source (output valid, data_byte, first, last, ip_src, ip_dst,
		protocol, ip_payload_length, input ready);
	modport sink (input valid, data_byte, first, last, ip_src, ip_dst,
		protocol, ip_payload_length, output ready);
endinterface

interface urc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [15:0] udp_sport;
	logic [15:0] udp_dport;
	logic [15:0] data_bytes;

	modport source (output valid, verdict, udp_sport, udp_dport, data_bytes,
		input ready);
	modport sink (input valid, verdict, udp_sport, udp_dport, data_bytes,
		output ready);
endinterface

>>> sv/urc_front.sv
module urc_front (
	input  logic              clk,
	input  logic              arst_n,
	urc_seg_if.sink           seg,
	output urc_pkg::urc_qctl_t qctl,
	input  logic              q_full,
	output urc_pkg::urc_rec_t rec
);
	import urc_pkg::*;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;
	logic [7:0]  proto_s1;
	logic [15:0] iplen_s1;
	logic [17:0] pa_s1;
	logic [17:0] pb_s1;

	logic [18:0] acc_q;
	logic [15:0] cnt_q;
	logic [7:0]  held_q;
	logic [15:0] src_q, dst_q, hlen_q, csum_q, iplen_q;
	logic [7:0]  proto_q;

	logic        advance;
	logic [18:0] acc_b, acc_n;
	logic [15:0] cnt_b, cnt_n;
	logic [7:0]  held_b, held_n;
	logic [15:0] src_b, dst_b, hlen_b, csum_b, iplen_b;
	logic [15:0] src_n, dst_n, hlen_n, csum_n;
	logic [7:0]  proto_b;

	assign advance   = vld_s1 && (!last_s1 || !q_full);
	assign seg.ready = !vld_s1 || advance;

	// input stage; the pseudo-header is pre-summed in two halves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (seg.valid && seg.ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready) begin
			byte_s1  <= seg.data_byte;
			first_s1 <= seg.first;
			last_s1  <= seg.last;
			proto_s1 <= seg.protocol;
			iplen_s1 <= seg.ip_payload_length;
			pa_s1    <= {2'b00, seg.ip_src[31:16]} + {2'b00, seg.ip_src[15:0]}
				+ {2'b00, seg.ip_dst[31:16]};
			pb_s1    <= {2'b00, seg.ip_dst[15:0]} + {10'd0, UDP_PROTO}
				+ {2'b00, seg.ip_payload_length};
		end
	end

	// acc holds an unfolded sum: its value mod 0xFFFF is acc[15:0] + acc[18:16]
	always_comb begin
		if (first_s1) begin
			acc_b   = {1'b0, pa_s1} + {1'b0, pb_s1};
			cnt_b   = '0;
			held_b  = '0;
			src_b   = '0;
			dst_b   = '0;
			hlen_b  = '0;
			csum_b  = '0;
			proto_b = proto_s1;
			iplen_b = iplen_s1;
		end else begin
			acc_b   = acc_q;
			cnt_b   = cnt_q;
			held_b  = held_q;
			src_b   = src_q;
			dst_b   = dst_q;
			hlen_b  = hlen_q;
			csum_b  = csum_q;
			proto_b = proto_q;
			iplen_b = iplen_q;
		end

		acc_n  = acc_b;
		cnt_n  = cnt_b;
		held_n = held_b;
		src_n  = src_b;
		dst_n  = dst_b;
		hlen_n = hlen_b;
		csum_n = csum_b;
		if (cnt_b != MASK16) begin
			if (cnt_b < 16'd2) begin
				src_n = {src_b[7:0], byte_s1};
			end else if (cnt_b < 16'd4) begin
				dst_n = {dst_b[7:0], byte_s1};
			end else if (cnt_b < 16'd6) begin
				hlen_n = {hlen_b[7:0], byte_s1};
			end else if (cnt_b < HDR_BYTES) begin
				csum_n = {csum_b[7:0], byte_s1};
			end
			if (cnt_b[0]) begin
				acc_n = {3'b000, acc_b[15:0]} + {16'd0, acc_b[18:16]}
					+ {3'b000, held_b, byte_s1};
			end else begin
				held_n = byte_s1;
			end
			cnt_n = cnt_b + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			held_q  <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			hlen_q  <= '0;
			csum_q  <= '0;
			proto_q <= '0;
			iplen_q <= '0;
		end else if (advance) begin
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			held_q  <= held_n;
			src_q   <= src_n;
			dst_q   <= dst_n;
			hlen_q  <= hlen_n;
			csum_q  <= csum_n;
			proto_q <= proto_b;
			iplen_q <= iplen_b;
		end
	end

	assign qctl.push = advance && last_s1;

	assign rec.proto    = proto_b;
	assign rec.ip_len   = iplen_b;
	assign rec.count    = cnt_n;
	assign rec.src_port = src_n;
	assign rec.dst_port = dst_n;
	assign rec.hdr_len  = hlen_n;
	assign rec.rx_csum  = csum_n;
	assign rec.acc      = acc_n;
	assign rec.held     = held_n;

endmodule

>>> sv/urc_fifo.sv
module urc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  urc_pkg::urc_qctl_t qctl,
	input  urc_pkg::urc_rec_t  wr_rec,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output urc_pkg::urc_rec_t  rd_rec
);
	import urc_pkg::*;

	urc_rec_t         mem_q [QDEPTH];
	logic [QAW-1:0]   wp_q, rp_q;
	logic [QAW:0]     cnt_q;

	assign full   = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_rec = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wp_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (qctl.push) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QAW'(1);
			end
			case ({qctl.push, pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QDEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

>>> sv/urc_back.sv
module urc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  urc_pkg::urc_rec_t rec,
	input  logic              empty,
	output logic              pop,
	urc_res_if.source         res
);
	import urc_pkg::*;

	logic        ov_q;
	verdict_t    verdict_q;
	logic [15:0] sport_q, dport_q, dbytes_q;

	logic [16:0] fold;
	logic        sum_ok;
	verdict_t    verdict;
	logic [15:0] dbytes;

	assign pop = !empty && (!ov_q || res.ready);

	// odd byte count: pad the held byte as a high half
	always_comb begin
		fold = {1'b0, rec.acc[15:0]} + {14'd0, rec.acc[18:16]}
			+ (rec.count[0] ? {1'b0, rec.held, 8'd0} : 17'd0);
		sum_ok = fold[16] ? (fold[15:0] == SUM_OK_LO) : (fold[15:0] == MASK16);

		dbytes = '0;
		if (rec.proto != UDP_PROTO) begin
			verdict = VERDICT_INVALID;
		end else if (rec.ip_len < HDR_BYTES || rec.count < HDR_BYTES) begin
			verdict = VERDICT_LEN_ERR;
		end else if (rec.src_port == '0 || rec.dst_port == '0) begin
			verdict = VERDICT_INVALID;
		end else if (rec.hdr_len < HDR_BYTES || rec.hdr_len != rec.ip_len
			|| rec.hdr_len != rec.count) begin
			verdict = VERDICT_LEN_ERR;
		end else if (rec.rx_csum != '0 && !sum_ok) begin
			verdict = VERDICT_CSUM_ERR;
		end else begin
			verdict = VERDICT_ACCEPT;
			dbytes  = rec.hdr_len - HDR_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (pop) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict;
			sport_q   <= rec.src_port;
			dport_q   <= rec.dst_port;
			dbytes_q  <= dbytes;
		end
	end

	assign res.valid      = ov_q;
	assign res.verdict    = verdict_q;
	assign res.udp_sport  = sport_q;
	assign res.udp_dport  = dport_q;
	assign res.data_bytes = dbytes_q;

endmodule

>>> sv/udp_receive_checker_unit.sv
// UDP receive checker: one segment byte per word, one result word per segment.
// Throughput: one byte per cycle sustained while the queue can take each last byte;
// the running sum takes one add per byte pair. A last byte passes the input
// register, the state update into a 2-entry queue and the verdict output register.
// Reset: arst_n clears the running state, queue pointers and valid flags at once.
module udp_receive_checker_unit (
	input  logic      clk,
	input  logic      arst_n,
	urc_seg_if.sink   seg,
	urc_res_if.source res
);
	import urc_pkg::*;

	urc_qctl_t qctl;
	urc_rec_t  wr_rec, rd_rec;
	logic      full, empty, pop;

	urc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg),
		.qctl   (qctl),
		.q_full (full),
		.rec    (wr_rec)
	);

	urc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qctl   (qctl),
		.wr_rec (wr_rec),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_rec (rd_rec)
	);

	urc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rd_rec),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

endmodule

>>> tb/tb_udp_receive_checker_unit.sv
`timescale 1ns / 100ps

module tb_udp_receive_checker_unit;
	import urc_pkg::*;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first;
		logic        last;
		logic [31:0] ip_src;
		logic [31:0] ip_dst;
		logic [7:0]  protocol;
		logic [15:0] ip_payload_length;
	} seg_word_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [15:0] udp_sport;
		logic [15:0] udp_dport;
		logic [15:0] data_bytes;
	} verdict_word_t;

	typedef logic [7:0] octet_q_t[$];

	class udp_rx_scoreboard;
		logic [15:0]   run_sum;
		logic [15:0]   byte_count;
		logic [15:0]   src_port;
		logic [15:0]   dst_port;
		logic [15:0]   hdr_len;
		logic [15:0]   rx_csum;
		logic [15:0]   ip_len;
		logic [7:0]    held;
		logic [7:0]    proto;
		verdict_word_t verdict_q[$];
		int unsigned   mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + {15'd0, s[16]};
		endfunction

		function void clear();
			run_sum    = '0;
			byte_count = '0;
			src_port   = '0;
			dst_port   = '0;
			hdr_len    = '0;
			rx_csum    = '0;
			ip_len     = '0;
			held       = '0;
			proto      = '0;
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		function void note_byte(seg_word_t w);
			logic [15:0]   total;
			verdict_word_t exp;
			if (w.first) begin
				clear();
				proto   = w.protocol;
				ip_len  = w.ip_payload_length;
				run_sum = ones_add(run_sum, w.ip_src[31:16]);
				run_sum = ones_add(run_sum, w.ip_src[15:0]);
				run_sum = ones_add(run_sum, w.ip_dst[31:16]);
				run_sum = ones_add(run_sum, w.ip_dst[15:0]);
				run_sum = ones_add(run_sum, {8'd0, UDP_PROTO});
				run_sum = ones_add(run_sum, ip_len);
			end
			// count saturates; bytes past it are dropped entirely
			if (byte_count != MASK16) begin
				case (byte_count)
					16'd0, 16'd1: src_port = {src_port[7:0], w.data_byte};
					16'd2, 16'd3: dst_port = {dst_port[7:0], w.data_byte};
					16'd4, 16'd5: hdr_len = {hdr_len[7:0], w.data_byte};
					16'd6, 16'd7: rx_csum = {rx_csum[7:0], w.data_byte};
					default: ;
				endcase
				if (byte_count[0])
					run_sum = ones_add(run_sum, {held, w.data_byte});
				else
					held = w.data_byte;
				byte_count = byte_count + 16'd1;
			end
			if (!w.last)
				return;
			total = byte_count[0] ? ones_add(run_sum, {held, 8'h00}) : run_sum;
			exp.udp_sport  = src_port;
			exp.udp_dport  = dst_port;
			exp.data_bytes = '0;
			if (proto != UDP_PROTO)
				exp.verdict = VERDICT_INVALID;
			else if (ip_len < HDR_BYTES || byte_count < HDR_BYTES)
				exp.verdict = VERDICT_LEN_ERR;
			else if (src_port == 16'd0 || dst_port == 16'd0)
				exp.verdict = VERDICT_INVALID;
			else if (hdr_len < HDR_BYTES || hdr_len != ip_len || hdr_len != byte_count)
				exp.verdict = VERDICT_LEN_ERR;
			else if (rx_csum != 16'd0 && total != MASK16)
				exp.verdict = VERDICT_CSUM_ERR;
			else begin
				exp.verdict    = VERDICT_ACCEPT;
				exp.data_bytes = hdr_len - HDR_BYTES;
			end
			verdict_q.push_back(exp);
		endfunction

		function void report(string what, verdict_word_t e, verdict_word_t a);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s exp v=%0d sp=%h dp=%h n=%0d got v=%0d sp=%h dp=%h n=%0d",
					$time, what, e.verdict, e.udp_sport, e.udp_dport, e.data_bytes,
					a.verdict, a.udp_sport, a.udp_dport, a.data_bytes);
		endfunction

		function void check_verdict(verdict_word_t a);
			verdict_word_t e;
			if (verdict_q.size() == 0) begin
				report("unexpected result", '0, a);
				return;
			end
			e = verdict_q.pop_front();
			if (a.verdict !== e.verdict || a.udp_sport !== e.udp_sport ||
				a.udp_dport !== e.udp_dport || a.data_bytes !== e.data_bytes)
				report("mismatch", e, a);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	urc_seg_if seg_bus ();
	urc_res_if res_bus ();

	udp_receive_checker_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_bus),
		.res    (res_bus)
	);

	udp_rx_scoreboard sb;
	int unsigned      words_sent = 0;
	bit               tx_calm = 1'b0;
	bit               rx_calm = 1'b0;
	int unsigned      rx_hold = 0;

	always #5 clk = ~clk;

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input seg_word_t w);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			seg_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg_bus.valid             <= 1'b1;
		seg_bus.data_byte         <= w.data_byte;
		seg_bus.first             <= w.first;
		seg_bus.last              <= w.last;
		seg_bus.ip_src            <= w.ip_src;
		seg_bus.ip_dst            <= w.ip_dst;
		seg_bus.protocol          <= w.protocol;
		seg_bus.ip_payload_length <= w.ip_payload_length;
		@(posedge clk);
		while (!seg_bus.ready)
			@(posedge clk);
		sb.note_byte(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_segment(input octet_q_t b, input logic [31:0] sip,
		input logic [31:0] dip, input logic [7:0] proto, input logic [15:0] ip_len,
		input bit with_first, input bit with_last);
		seg_word_t w;
		foreach (b[i]) begin
			w.data_byte = b[i];
			w.first     = with_first && (i == 0);
			w.last      = with_last && (i == b.size() - 1);
			if (w.first) begin
				w.ip_src            = sip;
				w.ip_dst            = dip;
				w.protocol          = proto;
				w.ip_payload_length = ip_len;
			end else begin
				// ignored off the first word, so keep them moving
				w.ip_src            = $urandom;
				w.ip_dst            = $urandom;
				w.protocol          = 8'($urandom_range(0, 255));
				w.ip_payload_length = 16'($urandom_range(0, 65535));
			end
			send_word(w);
		end
	endtask

	function automatic octet_q_t build_udp(logic [31:0] sip, logic [31:0] dip,
		logic [15:0] ip_len, logic [15:0] sport, logic [15:0] dport,
		int unsigned payload, logic [15:0] hdr, bit with_csum);
		octet_q_t    b;
		logic [15:0] s;
		logic [15:0] c;
		b = {sport[15:8], sport[7:0], dport[15:8], dport[7:0],
			hdr[15:8], hdr[7:0], 8'h00, 8'h00};
		repeat (payload)
			b.push_back(8'($urandom_range(0, 255)));
		if (with_csum) begin
			s = udp_rx_scoreboard::ones_add(sip[31:16], sip[15:0]);
			s = udp_rx_scoreboard::ones_add(s, dip[31:16]);
			s = udp_rx_scoreboard::ones_add(s, dip[15:0]);
			s = udp_rx_scoreboard::ones_add(s, {8'd0, UDP_PROTO});
			s = udp_rx_scoreboard::ones_add(s, ip_len);
			for (int i = 0; i < b.size(); i += 2)
				s = udp_rx_scoreboard::ones_add(s,
					{b[i], (i + 1 < b.size()) ? b[i + 1] : 8'h00});
			c = ~s;
			if (c == 16'd0)
				c = 16'hFFFF;
			b[6] = c[15:8];
			b[7] = c[7:0];
		end
		return b;
	endfunction

	initial begin : stimulus
		octet_q_t    b;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] ip_len;
		logic [15:0] hdr;
		logic [7:0]  proto;
		int unsigned payload;
		int unsigned k;
		int unsigned idx;
		int unsigned cut;
		int unsigned base;
		int unsigned seg_idx;
		int unsigned pressure_left;
		bit          first_on;
		bit          last_on;
		bit          csum_on;

		sb = new();
		arst_n                    = 1'b0;
		seg_bus.valid             = 1'b0;
		seg_bus.data_byte         = '0;
		seg_bus.first             = 1'b0;
		seg_bus.last              = 1'b0;
		seg_bus.ip_src            = '0;
		seg_bus.ip_dst            = '0;
		seg_bus.protocol          = '0;
		seg_bus.ip_payload_length = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bytes straight after reset with no first word
		send_segment({8'h00, 8'hFF, 8'h5A}, '0, '0, '0, '0, 1'b0, 1'b1);
		// one-byte segment
		send_segment({8'hFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, UDP_PROTO, 16'hFFFF, 1'b1, 1'b1);
		// smallest good segment, all-ones ports
		b = build_udp('0, '0, 16'd8, 16'hFFFF, 16'hFFFF, 0, 16'd8, 1'b1);
		send_segment(b, '0, '0, UDP_PROTO, 16'd8, 1'b1, 1'b1);
		// stray bytes after a last, carried on the old segment
		send_segment({8'h00, 8'hFF}, '0, '0, '0, '0, 1'b0, 1'b1);
		// IP length of zero, odd byte count
		b = build_udp(32'hFFFF_FFFF, '0, 16'd0, 16'd1, 16'd1, 1, 16'd9, 1'b1);
		send_segment(b, 32'hFFFF_FFFF, '0, UDP_PROTO, 16'd0, 1'b1, 1'b1);

		base          = words_sent;
		seg_idx       = 0;
		pressure_left = 0;
		while (words_sent - base < 1100) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			if (seg_idx == 10) begin
				rx_hold       = 400;
				pressure_left = 24;
			end
			if (seg_idx % 15 == 14 && sb.pending() != 0) begin
				seg_bus.valid <= 1'b0;
				while (sb.pending() != 0)
					@(negedge clk);
			end
			k       = $urandom_range(0, 99);
			sip     = $urandom;
			dip     = $urandom;
			sport   = 16'($urandom_range(1, 65535));
			dport   = 16'($urandom_range(1, 65535));
			payload = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
				: $urandom_range(0, 12);
			if (pressure_left > 0) begin
				tx_calm = 1'b1;
				payload = $urandom_range(0, 3);
				k       = 0;
				pressure_left--;
			end
			ip_len   = 16'(8 + payload);
			hdr      = ip_len;
			proto    = UDP_PROTO;
			first_on = 1'b1;
			last_on  = 1'b1;
			csum_on  = !(k >= 60 && k < 70);
			if (k >= 82 && k < 86) begin
				if ($urandom_range(0, 1))
					sport = '0;
				else
					dport = '0;
			end
			if (k >= 90 && k < 93)
				hdr = 16'($urandom_range(0, 80));
			b = build_udp(sip, dip, ip_len, sport, dport, payload, hdr, csum_on);
			if (k >= 70 && k < 78) begin
				idx    = $urandom_range(6, b.size() - 1);
				b[idx] = b[idx] ^ 8'(1 << $urandom_range(0, 7));
			end
			if (k >= 78 && k < 82)
				proto = 8'($urandom_range(0, 255));
			if (k >= 86 && k < 90)
				ip_len = 16'($urandom_range(0, 65535));
			if (k >= 93 && k < 96) begin
				b.delete();
				repeat ($urandom_range(1, 7))
					b.push_back(8'($urandom_range(0, 255)));
				ip_len = 16'($urandom_range(0, 65535));
			end
			if (k >= 96 && k < 98) begin
				b.delete();
				repeat ($urandom_range(1, 6))
					b.push_back(8'($urandom_range(0, 255)));
				first_on = 1'b0;
			end
			if (k >= 98) begin
				// abandoned segment, restarted by the next first word
				cut = $urandom_range(0, b.size() - 1);
				repeat (cut)
					void'(b.pop_back());
				last_on = 1'b0;
			end
			send_segment(b, sip, dip, proto, ip_len, first_on, last_on);
			seg_idx++;
		end
		seg_bus.valid <= 1'b0;

		while (sb.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : result_sink
		int            stall;
		int            taken;
		verdict_word_t got;
		res_bus.ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				res_bus.ready <= 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			if (taken % 16 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			stall = rx_calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!res_bus.valid)
				@(posedge clk);
			got.verdict    = res_bus.verdict;
			got.udp_sport  = res_bus.udp_sport;
			got.udp_dport  = res_bus.udp_dport;
			got.data_bytes = res_bus.data_bytes;
			sb.check_verdict(got);
			taken++;
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
